[rtl/hicp_pkg.sv]
package hicp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned IdW    = 64;
  localparam int unsigned GroupW = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned OutW   = 72;  // value + status, padded to whole bytes

  localparam logic [CountW-1:0] ID_DIGITS    = 5'd16;
  localparam logic [CountW-1:0] TOTAL_DIGITS = 5'd20;

  localparam logic [CharW-1:0] CH_0     = 8'h30;
  localparam logic [CharW-1:0] CH_9     = 8'h39;
  localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
  localparam logic [CharW-1:0] CH_LO_F  = 8'h66;
  localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CH_UP_F  = 8'h46;
  localparam logic [CharW-1:0] CH_UP_O  = 8'h4f;
  localparam logic [CharW-1:0] CH_LO_O  = 8'h6f;
  localparam logic [CharW-1:0] CH_UP_I  = 8'h49;
  localparam logic [CharW-1:0] CH_LO_L  = 8'h6c;
  localparam logic [NibW-1:0]  HEX_TEN  = 4'd10;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    logic            valid;
    logic [NibW-1:0] nibble;
  } digit_t;

  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] value;
    status_t        status;
  } result_t;

  function automatic digit_t classify(input logic [CharW-1:0] c);
    digit_t d;
    logic [CharW-1:0] diff;
    d.valid  = 1'b1;
    d.nibble = '0;
    diff     = '0;
    priority if (c >= CH_0 && c <= CH_9) begin
      diff     = c - CH_0;
      d.nibble = diff[NibW-1:0];
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      diff     = c - CH_LO_A;
      d.nibble = diff[NibW-1:0] + HEX_TEN;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      diff     = c - CH_UP_A;
      d.nibble = diff[NibW-1:0] + HEX_TEN;
    end else if (c == CH_UP_O || c == CH_LO_O) begin
      d.nibble = 4'd0;
    end else if (c == CH_UP_I || c == CH_LO_L) begin
      d.nibble = 4'd1;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

[rtl/hicp_classify.sv]
module hicp_classify (
  input  logic [hicp_pkg::CharW-1:0] char_byte,
  output hicp_pkg::digit_t           digit
);
  import hicp_pkg::*;

  assign digit = classify(char_byte);

endmodule

[rtl/hicp_accum.sv]
module hicp_accum (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             last,
  input  hicp_pkg::digit_t digit,
  output hicp_pkg::result_t result
);
  import hicp_pkg::*;

  logic [CountW-1:0] digit_count, digit_count_next;
  logic [IdW-1:0]    id_accumulator, id_accumulator_next;
  logic [GroupW-1:0] check_group, check_group_next;
  logic [GroupW-1:0] group_xor;
  logic              take;

  assign take = accept && digit.valid && (digit_count < TOTAL_DIGITS);

  always_comb begin
    digit_count_next    = digit_count;
    id_accumulator_next = id_accumulator;
    check_group_next    = check_group;
    if (take) begin
      if (digit_count < ID_DIGITS) begin
        id_accumulator_next = {id_accumulator[IdW-NibW-1:0], digit.nibble};
      end else begin
        check_group_next = {check_group[GroupW-NibW-1:0], digit.nibble};
      end
      digit_count_next = digit_count + 5'd1;
    end
  end

  // identifier is frozen once sixteen digits are in, so fold it at the end
  assign group_xor = id_accumulator_next[63:48] ^ id_accumulator_next[47:32] ^
                     id_accumulator_next[31:16] ^ id_accumulator_next[15:0];

  always_comb begin
    result.valid  = accept && last;
    result.value  = '0;
    result.status = STATUS_OK;
    if (digit_count_next < TOTAL_DIGITS) begin
      result.status = STATUS_SHORT;
    end else if (check_group_next != group_xor) begin
      result.status = STATUS_MISMATCH;
    end else begin
      result.value = id_accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      digit_count    <= '0;
      id_accumulator <= '0;
      check_group    <= '0;
    end else begin
      digit_count    <= digit_count_next;
      id_accumulator <= id_accumulator_next;
      check_group    <= check_group_next;
    end
  end

endmodule

[rtl/hex_id_check_parse.sv]
// Hex identifier parser: takes one character per item and, on the item with
// tlast set, returns one result holding the 64-bit identifier made of the first
// sixteen hex digits and a status (accepted, too few digits, check mismatch);
// value is zero unless accepted. Non-digit bytes are skipped, O/o read as 0,
// I/l read as 1, digits past the twentieth are ignored. One item is taken per
// clock while s_axis_tready is high; the result appears in the output register
// in the cycle after the last item is taken. s_axis_tready is low only while
// that output register holds a result the sink has not yet taken.
module hex_id_check_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [hicp_pkg::CharW-1:0] s_axis_tdata,  // [7:0] char_byte
  input  logic                       s_axis_tlast,  // last
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [hicp_pkg::OutW-1:0]  m_axis_tdata   // [63:0] value, [65:64] status, rest 0
);
  import hicp_pkg::*;

  digit_t  digit;
  result_t result;
  logic    accept;
  logic [IdW-1:0] out_value;
  status_t        out_status;

  assign s_axis_tready = m_axis_tready || !m_axis_tvalid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  hicp_classify u_classify (
    .char_byte (s_axis_tdata),
    .digit     (digit)
  );

  hicp_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .last   (s_axis_tlast),
    .digit  (digit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && result.valid) begin
      out_value  <= result.value;
      out_status <= result.status;
    end
  end

  assign m_axis_tdata = {{(OutW-IdW-2){1'b0}}, out_status, out_value};

endmodule

[rtl/hicp_checker.sv]
module hicp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       s_axis_tlast,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [hicp_pkg::OutW-1:0]  m_axis_tdata
);
  import hicp_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[65:64] != 2'd3)
    else $error("undefined status code");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[65:64] != STATUS_OK |-> m_axis_tdata[63:0] == 64'd0)
    else $error("failed result carries nonzero value");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(in_acc && s_axis_tlast))
    else $error("result without a last item");

  a_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

bind hex_id_check_parse hicp_checker u_hicp_checker (.*);
